### sv/bwts_pkg.sv
// ----------------------------------------------------------------------------
// bwts_pkg
// Shared types and constants of the bilinear wrap texture sampler.
// ----------------------------------------------------------------------------
package bwts_pkg;

  localparam int unsigned TexelDepth = 65536;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned PalDepth   = 256;
  localparam int unsigned PosFrac    = 24;

  typedef enum logic [1:0] {
    CmdWriteTexel   = 2'd0,
    CmdWritePalette = 2'd1,
    CmdSample       = 2'd2,
    CmdNone         = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RegWidth    = 3'd0,
    RegHeight   = 3'd1,
    RegPaletted = 3'd2,
    RegOffsetX  = 3'd3,
    RegOffsetY  = 3'd4,
    RegScaleX   = 3'd5,
    RegScaleY   = 3'd6,
    RegNone     = 3'd7
  } reg_e;

endpackage

### sv/bwts_axis_map.sv
// ----------------------------------------------------------------------------
// bwts_axis_map
// Maps one axis of a sample position to a wrapped texel coordinate and a
// fraction. Pipelined: subtract, scale, size, then a multi-step wrap.
// Stages: four arithmetic stages, WS wrap stages and the output
// register. One beat per cycle while en_i is high.
// ----------------------------------------------------------------------------
module bwts_axis_map #(
  parameter int unsigned FRAC_BITS = bwts_pkg::FracBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [15:0]          pos_i,
  input  logic signed [16:0]   off_i,
  input  logic [15:0]          scale_i,
  input  logic [8:0]           size_i,
  output logic [8:0]           coord_o,
  output logic [8:0]           coord1_o,
  output logic [FRAC_BITS-0:0] one_m_frac_o,
  output logic [FRAC_BITS-1:0] frac_o
);
  localparam int unsigned PF = bwts_pkg::PosFrac;

  // stage 1: difference, 18 bits signed
  logic signed [17:0] d_q;
  logic [15:0] sc_q;
  logic [8:0] sz1_q;
  // stage 2: times scale, 34 bits signed
  logic signed [33:0] ds_q;
  logic [8:0] sz2_q;
  // stage 3: times size, 44 bits signed
  logic signed [43:0] p_q;
  logic [8:0] sz3_q;
  // stage 4: integer part (floor) and fraction
  logic signed [19:0] ip_q;
  logic [FRAC_BITS-1:0] f4_q;
  logic [8:0] sz4_q;

  logic [8:0] sz_eff;
  assign sz_eff = (size_i == 9'd0) ? 9'd1 : size_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q   <= $signed({2'b00, pos_i}) - 18'(off_i);
      sc_q  <= scale_i;
      sz1_q <= sz_eff;
      ds_q  <= 34'(d_q) * $signed({1'b0, sc_q});
      sz2_q <= sz1_q;
      p_q   <= 44'(ds_q) * $signed({1'b0, sz2_q});
      sz3_q <= sz2_q;
      ip_q  <= p_q[43:PF];
      f4_q  <= p_q[PF-1 -: FRAC_BITS];
      sz4_q <= sz3_q;
    end
  end

  // wrap: floor result ip lies in (-2^19, 2^19); reduce by subtracting
  // size shifted, one bit per stage over 11 stages on a sign-corrected value
  localparam int unsigned WS = 11;
  logic [19:0] r_q [WS+1];
  logic [8:0] s_q [WS+1];
  logic [FRAC_BITS-1:0] f_q [WS+1];
  logic n_q [WS+1];

  assign r_q[0] = ip_q[19] ? 20'(-ip_q) : 20'(ip_q);
  assign s_q[0] = sz4_q;
  assign f_q[0] = f4_q;
  assign n_q[0] = ip_q[19];

  for (genvar k = 0; k < WS; k++) begin : g_wrap
    localparam int unsigned SH = WS - 1 - k;
    logic [19:0] r_s;
    logic [19:0] r_d;
    logic [19:0] sub;
    logic [8:0] s_s;
    logic [FRAC_BITS-1:0] f_s;
    logic n_s;
    assign sub = 20'(s_q[k]) << SH;
    assign r_d = (r_q[k] >= sub) ? r_q[k] - sub : r_q[k];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_s <= r_d;
        s_s <= s_q[k];
        f_s <= f_q[k];
        n_s <= n_q[k];
      end
    end
    assign r_q[k+1] = r_s;
    assign s_q[k+1] = s_s;
    assign f_q[k+1] = f_s;
    assign n_q[k+1] = n_s;
  end

  logic [8:0] rem;
  logic [8:0] c0;
  assign rem = r_q[WS][8:0];
  assign c0 = (n_q[WS] && rem != 9'd0) ? s_q[WS] - rem : rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_o      <= '0;
      coord1_o     <= '0;
      frac_o       <= '0;
      one_m_frac_o <= '0;
    end else if (en_i) begin
      coord_o      <= c0;
      coord1_o     <= (c0 + 9'd1 >= s_q[WS]) ? 9'd0 : c0 + 9'd1;
      frac_o       <= f_q[WS];
      one_m_frac_o <= ((FRAC_BITS+1)'(1) << FRAC_BITS) - (FRAC_BITS+1)'(f_q[WS]);
    end
  end
endmodule

### sv/bilinear_wrap_texture_sampler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_wrap_texture_sampler_unit
// Bilinear texture sampler with wrap-around addressing and optional palette.
// ----------------------------------------------------------------------------
// Input beats on s_axis: tdata holds command, write_address, write_data,
// pos_x, pos_y. Commands 0 and 1 write the texel store or palette and give
// no output; command 2 samples and gives one output beat on m_axis with
// red_out, green_out, blue_out (unsigned 8.8). Command 3 is dropped.
// Configuration is written on cfg_we_i/cfg_addr_i/cfg_data_i; the user must
// write it only while idle; the block does not enforce it. Throughput: one
// beat per cycle unless m_axis stalls. The texel store is four replicated
// memories so the four neighbours are read in the same cycle; the palette
// likewise. A sample passes the axis map pipeline (scale multiplies and the
// bit-per-stage wrap), texel read, palette read and the two blend stages
// before m_axis_tvalid. The whole pipeline advances only when the output
// stage can take a beat, so a stalled receiver holds s_axis_tready low and
// loses nothing. Reset clears valid bits, configuration and axis map
// outputs; memories hold undefined data. Writes enter the memories at the
// texel-read stage in order, so a sample after a write sees it.
// ----------------------------------------------------------------------------
module bilinear_wrap_texture_sampler_unit #(
  parameter int unsigned FRAC_BITS   = bwts_pkg::FracBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], write_address[17:2], write_data[41:18], pos_x[57:42],
  // pos_y[73:58], zero fill
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // red_out[15:0], green_out[31:16], blue_out[47:32]
  output logic [47:0]  m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_addr_i,
  input  logic [16:0]  cfg_data_i
);
  // power of two; texel addresses wrap by truncation
  localparam int unsigned TEXEL_DEPTH = bwts_pkg::TexelDepth;
  localparam int unsigned AW = (TEXEL_DEPTH > 1) ? $clog2(TEXEL_DEPTH) : 1;
  localparam int unsigned MW = 18;
  localparam int unsigned LAT = 16;   // axis map latency
  localparam int unsigned SH = 2 * FRAC_BITS - 8;

  logic [8:0] width_q, height_q;
  logic pal_q;
  logic signed [16:0] offx_q, offy_q;
  logic [15:0] sclx_q, scly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 9'd256; height_q <= 9'd256; pal_q <= 1'b0;
      offx_q <= '0; offy_q <= '0; sclx_q <= 16'd256; scly_q <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (bwts_pkg::reg_e'(cfg_addr_i))
        bwts_pkg::RegWidth:    width_q  <= cfg_data_i[8:0];
        bwts_pkg::RegHeight:   height_q <= cfg_data_i[8:0];
        bwts_pkg::RegPaletted: pal_q    <= cfg_data_i[0];
        bwts_pkg::RegOffsetX:  offx_q   <= cfg_data_i;
        bwts_pkg::RegOffsetY:  offy_q   <= cfg_data_i;
        bwts_pkg::RegScaleX:   sclx_q   <= cfg_data_i[15:0];
        bwts_pkg::RegScaleY:   scly_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic [1:0] in_cmd;
  logic [15:0] in_addr, in_px, in_py;
  logic [23:0] in_wd;
  assign in_cmd  = s_axis_tdata[1:0];
  assign in_addr = s_axis_tdata[17:2];
  assign in_wd   = s_axis_tdata[41:18];
  assign in_px   = s_axis_tdata[57:42];
  assign in_py   = s_axis_tdata[73:58];

  // global pipeline enable; output register
  logic out_v_q;
  logic en;
  assign en = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  logic acc;
  assign acc = s_axis_tvalid && en;

  // axis mapping
  logic [8:0] x0, x1, y0, y1;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [FRAC_BITS:0] ofx, ofy;
  logic [8:0] w_eff;
  assign w_eff = (width_q == 9'd0) ? 9'd1 : width_q;

  bwts_axis_map #(.FRAC_BITS(FRAC_BITS)) u_map_x (
    .clk_i, .rst_ni, .en_i(en), .pos_i(in_px), .off_i(offx_q), .scale_i(sclx_q),
    .size_i(width_q), .coord_o(x0), .coord1_o(x1), .one_m_frac_o(ofx), .frac_o(fx)
  );
  bwts_axis_map #(.FRAC_BITS(FRAC_BITS)) u_map_y (
    .clk_i, .rst_ni, .en_i(en), .pos_i(in_py), .off_i(offy_q), .scale_i(scly_q),
    .size_i(height_q), .coord_o(y0), .coord1_o(y1), .one_m_frac_o(ofy), .frac_o(fy)
  );

  // delay line for command/write payload to match the axis map
  logic [1:0] cmd_q [LAT];
  logic [15:0] wa_q [LAT];
  logic [23:0] wd_q [LAT];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) cmd_q[i] <= bwts_pkg::CmdNone;
    end else if (en) begin
      cmd_q[0] <= acc ? in_cmd : bwts_pkg::CmdNone;
      for (int i = 1; i < LAT; i++) cmd_q[i] <= cmd_q[i-1];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      wa_q[0] <= in_addr;
      wd_q[0] <= in_wd;
      for (int i = 1; i < LAT; i++) begin
        wa_q[i] <= wa_q[i-1];
        wd_q[i] <= wd_q[i-1];
      end
    end
  end

  logic [1:0] cmd_m;
  logic [15:0] wa_m;
  logic [23:0] wd_m;
  assign cmd_m = cmd_q[LAT-1];
  assign wa_m  = wa_q[LAT-1];
  assign wd_m  = wd_q[LAT-1];

  // texel addresses (mod depth)
  logic [AW-1:0] ta [4];
  logic [17:0] row0, row1;
  assign row0 = 18'(y0) * 18'(w_eff);
  assign row1 = 18'(y1) * 18'(w_eff);
  always_comb begin
    ta[0] = AW'((MW+1)'(row0) + (MW+1)'(x0));
    ta[1] = AW'((MW+1)'(row1) + (MW+1)'(x0));
    ta[2] = AW'((MW+1)'(row0) + (MW+1)'(x1));
    ta[3] = AW'((MW+1)'(row1) + (MW+1)'(x1));
  end

  logic [19:0] twa;
  assign twa = 20'(wa_m);
  logic twe, pwe;
  assign twe = en && cmd_m == bwts_pkg::CmdWriteTexel && twa < 20'(TEXEL_DEPTH);
  assign pwe = en && cmd_m == bwts_pkg::CmdWritePalette && wa_m < 16'(bwts_pkg::PalDepth);

  logic [23:0] tex_rd [4];
  logic [23:0] pal_rd [4];

  for (genvar k = 0; k < 4; k++) begin : g_mem
    logic [23:0] tex_mem [TEXEL_DEPTH];
    logic [23:0] pal_mem [bwts_pkg::PalDepth];
    logic [23:0] trd_q, prd_q;
    always_ff @(posedge clk_i) begin
      if (twe) tex_mem[AW'(wa_m)] <= wd_m;
      if (en) trd_q <= tex_mem[ta[k]];
    end
    always_ff @(posedge clk_i) begin
      if (pwe) pal_mem[wa_m[7:0]] <= wd_m;
      if (en) prd_q <= pal_mem[trd_q[7:0]];
    end
    assign tex_rd[k] = trd_q;
    assign pal_rd[k] = prd_q;
  end

  // fractions and command through the two read stages
  logic [FRAC_BITS-1:0] fx_a, fy_a, fx_b, fy_b;
  logic [FRAC_BITS:0] ofx_a, ofy_a, ofx_b, ofy_b;
  logic s_a, s_b, pal_b;
  logic [23:0] tx_b [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_a <= 1'b0; s_b <= 1'b0;
    end else if (en) begin
      s_a <= cmd_m == bwts_pkg::CmdSample;
      s_b <= s_a;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_a <= fx; fy_a <= fy; ofx_a <= ofx; ofy_a <= ofy;
      fx_b <= fx_a; fy_b <= fy_a; ofx_b <= ofx_a; ofy_b <= ofy_a;
      pal_b <= pal_q;
      for (int k = 0; k < 4; k++) tx_b[k] <= tex_rd[k];
    end
  end

  logic [23:0] t [4];
  always_comb begin
    for (int k = 0; k < 4; k++) t[k] = pal_b ? pal_rd[k] : tx_b[k];
  end

  // blend stage 1: vertical
  localparam int unsigned LW = FRAC_BITS + 9;
  logic [LW-1:0] lft_q [3], rgt_q [3];
  logic [FRAC_BITS-1:0] fx_c;
  logic [FRAC_BITS:0] ofx_c;
  logic s_c;
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        lft_q[c] <= LW'(t[0][16-8*c +: 8]) * LW'(ofy_b) + LW'(t[1][16-8*c +: 8]) * LW'(fy_b);
        rgt_q[c] <= LW'(t[2][16-8*c +: 8]) * LW'(ofy_b) + LW'(t[3][16-8*c +: 8]) * LW'(fy_b);
      end
      fx_c <= fx_b; ofx_c <= ofx_b;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s_c <= 1'b0;
    else if (en) s_c <= s_b;
  end

  // blend stage 2: horizontal into output register
  localparam int unsigned VW = 2 * FRAC_BITS + 9;
  logic [VW-1:0] v [3];
  always_comb begin
    for (int c = 0; c < 3; c++)
      v[c] = VW'(lft_q[c]) * VW'(ofx_c) + VW'(rgt_q[c]) * VW'(fx_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= s_c;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) m_axis_tdata[16*c +: 16] <= 16'(v[c] >> SH);
    end
  end
  assign m_axis_tvalid = out_v_q;
endmodule
